@@ rtl/arpc_pkg.sv @@
// ---------------------------------------------------------------------------
// ARP cache package
// Shared codes, constants and control structs of the ARP cache responder.
// ---------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

  // Field widths; IP, MAC and opcode widths are fixed by the ARP and Ethernet formats
  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int OPCODE_W = 16;
  localparam int ACTION_W = 3;
  localparam int AOP_W    = 2;

  // Received opcodes
  localparam logic [OPCODE_W-1:0] OP_REQUEST = 16'd1;
  localparam logic [OPCODE_W-1:0] OP_REPLY   = 16'd2;

  // Outgoing opcodes
  localparam logic [AOP_W-1:0] AOP_NONE    = 2'd0;
  localparam logic [AOP_W-1:0] AOP_REQUEST = 2'd1;
  localparam logic [AOP_W-1:0] AOP_REPLY   = 2'd2;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_IGNORED = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_HANDLED = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REPLY   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_HIT     = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_MISS    = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_BCAST   = 3'd5;

  // Broadcast addresses
  localparam logic [IP_W-1:0]  BCAST_IP  = {4{8'hFF}};
  localparam logic [MAC_W-1:0] BCAST_MAC = {6{8'hFF}};

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the input transaction
    logic scan;      // step the table scan
    logic out_load;  // register the result (and insert on a learn miss)
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_scan;  // transaction needs a table lookup
    logic match;       // compared entry equals the key
    logic exhausted;   // all valid entries compared, no match
  } stat_t;

  // One result transaction
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [MAC_W-1:0]    frame_dst_mac;
    logic [AOP_W-1:0]    arp_opcode;
    logic [IP_W-1:0]     arp_sender_ip;
    logic [MAC_W-1:0]    arp_target_mac;
    logic [IP_W-1:0]     arp_target_ip;
    logic [MAC_W-1:0]    resolved_mac;
    logic                learned;
    logic                table_full;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/arpc_ctrl.sv @@
// ---------------------------------------------------------------------------
// ARP cache controller
// Sequences capture, table scan and result strobe of one transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module arpc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  arpc_pkg::stat_t     stat,
  output arpc_pkg::cmd_t      cmd,
  output logic                busy,
  output logic                done
);
  import arpc_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    DECIDE,
    SCAN
  } state_t;

  state_t state;
  state_t state_next;

  // Commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = DECIDE;
        end
      end
      DECIDE: begin
        if (stat.needs_scan) begin
          state_next = SCAN;
        end else begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      SCAN: begin
        cmd.scan = 1'b1;
        if (stat.match || stat.exhausted) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  assign busy = (state != IDLE);

  // State and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.out_load;
    end
  end

endmodule

`default_nettype wire

@@ rtl/arpc_dp.sv @@
// ---------------------------------------------------------------------------
// ARP cache datapath
// Input capture, cache table with sequential scan, insert and result build.
// ---------------------------------------------------------------------------
`default_nettype none

module arpc_dp #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  arpc_pkg::cmd_t                    cmd,
  output arpc_pkg::stat_t                   stat,
  input  wire logic [arpc_pkg::IP_W-1:0]    own_ip,
  input  wire logic                         mode,
  input  wire logic [arpc_pkg::OPCODE_W-1:0] opcode,
  input  wire logic [arpc_pkg::MAC_W-1:0]   sender_mac,
  input  wire logic [arpc_pkg::IP_W-1:0]    sender_ip,
  input  wire logic [arpc_pkg::IP_W-1:0]    target_ip,
  output arpc_pkg::res_t                    res
);
  import arpc_pkg::*;

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  // Captured transaction
  logic                in_mode;
  logic [OPCODE_W-1:0] in_opcode;
  logic [MAC_W-1:0]    in_smac;
  logic [IP_W-1:0]     in_sip;
  logic [IP_W-1:0]     in_tip;

  // Table storage and scan
  logic [IP_W-1:0]  ip_mem  [TABLE_ENTRIES];
  logic [MAC_W-1:0] mac_mem [TABLE_ENTRIES];
  logic [IP_W-1:0]  rd_ip;
  logic [MAC_W-1:0] rd_mac;
  logic [CNT_W-1:0] rd_idx;
  logic             cmp_vld;
  logic [CNT_W-1:0] entry_count;

  logic [IP_W-1:0]  key;
  logic             rd_en;
  logic             tbl_full;
  logic             tip_own;
  logic             tip_bcast;
  logic             needs_scan;
  logic             insert_ok;
  logic             mem_we;
  res_t             res_next;

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_mode   <= mode;
      in_opcode <= opcode;
      in_smac   <= sender_mac;
      in_sip    <= sender_ip;
      in_tip    <= target_ip;
    end
  end

  // Learning keys on the sender IP, resolving on the target IP
  assign key       = in_mode ? in_tip : in_sip;
  assign tip_own   = (in_tip == own_ip);
  assign tip_bcast = (in_tip == BCAST_IP);
  assign tbl_full  = (entry_count >= FULL_CNT);

  // Which transactions look up the table
  always_comb begin
    needs_scan = 1'b0;
    if (in_mode) begin
      needs_scan = !tip_bcast;
    end else begin
      case (in_opcode)
        OP_REQUEST: needs_scan = tip_own;
        OP_REPLY:   needs_scan = 1'b1;
        default:    needs_scan = 1'b0;
      endcase
    end
  end

  assign stat.needs_scan = needs_scan;

  // Scan status: one entry read per cycle, compared in the next
  assign rd_en          = cmd.scan && (rd_idx < entry_count);
  assign stat.match     = cmp_vld && (rd_ip == key);
  assign stat.exhausted = !cmp_vld && (rd_idx >= entry_count);

  // Insert only at the end of a learning scan, never on a skipped transaction
  assign insert_ok = stat.exhausted && !tbl_full;
  assign mem_we    = cmd.scan && cmd.out_load && !in_mode && insert_ok;

  // Scan pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      cmp_vld <= 1'b0;
    end else if (cmd.load) begin
      rd_idx  <= '0;
      cmp_vld <= 1'b0;
    end else if (cmd.scan) begin
      cmp_vld <= rd_en;
      if (rd_en) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
    end
  end

  // Table memory: registered read, write at the fill count
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ip_mem[entry_count[IDX_W-1:0]]  <= key;
      mac_mem[entry_count[IDX_W-1:0]] <= in_smac;
    end
    if (rd_en) begin
      rd_ip  <= ip_mem[rd_idx[IDX_W-1:0]];
      rd_mac <= mac_mem[rd_idx[IDX_W-1:0]];
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (mem_we) begin
      entry_count <= entry_count + CNT_W'(1);
    end
  end

  // Result build
  always_comb begin
    res_next = '0;
    if (!in_mode) begin
      case (in_opcode)
        OP_REQUEST: begin
          res_next.action = ACT_HANDLED;
          if (tip_own) begin
            res_next.action         = ACT_REPLY;
            res_next.frame_dst_mac  = in_smac;
            res_next.arp_opcode     = AOP_REPLY;
            res_next.arp_sender_ip  = in_tip;
            res_next.arp_target_mac = in_smac;
            res_next.arp_target_ip  = in_sip;
            res_next.learned        = insert_ok;
            res_next.table_full     = stat.exhausted && tbl_full;
          end
        end
        OP_REPLY: begin
          res_next.action     = ACT_HANDLED;
          res_next.learned    = insert_ok;
          res_next.table_full = stat.exhausted && tbl_full;
        end
        default: begin
          res_next.action = ACT_IGNORED;
        end
      endcase
    end else if (tip_bcast) begin
      res_next.action       = ACT_BCAST;
      res_next.resolved_mac = BCAST_MAC;
    end else if (stat.match) begin
      res_next.action       = ACT_HIT;
      res_next.resolved_mac = rd_mac;
    end else begin
      res_next.action        = ACT_MISS;
      res_next.frame_dst_mac = BCAST_MAC;
      res_next.arp_opcode    = AOP_REQUEST;
      res_next.arp_sender_ip = own_ip;
      res_next.arp_target_ip = in_tip;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/arp_cache_responder.sv @@
// ---------------------------------------------------------------------------
// ARP cache responder
// ARP cache with responder for received packets and resolver for IP lookups.
// ---------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low. mode 0 feeds
//   a received ARP packet (opcode, sender_mac, sender_ip, target_ip); mode 1
//   asks to resolve target_ip. Each transaction gives one result, shown for
//   one cycle with done high; the receiver cannot stall it.
//   Transactions that skip the table (ignored, acknowledged, broadcast) go
//   from capture through the decide state straight to the result. A lookup
//   scans the table one entry per cycle from the first entry and stops at
//   a hit; a miss or a new learn scans every filled entry. One transaction
//   is in flight at a time, so the single-ported table scan also sets the
//   spacing between transactions.
//   A new transaction may start in the cycle its predecessor's result shows.
//   Learning appends to the table in the cycle the miss is found; a full
//   table drops the entry and raises table_full.
//   Reset empties the table and clears own_ip and own_mac. own_ip is at
//   address 0, own_mac at address 8 of the APB port; write them while idle.
// ---------------------------------------------------------------------------
`default_nettype none

module arp_cache_responder #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // command channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          mode,
  input  wire logic [arpc_pkg::OPCODE_W-1:0] opcode,
  input  wire logic [arpc_pkg::MAC_W-1:0]    sender_mac,
  input  wire logic [arpc_pkg::IP_W-1:0]     sender_ip,
  input  wire logic [arpc_pkg::IP_W-1:0]     target_ip,
  // result channel
  output logic                               done,
  output logic [arpc_pkg::ACTION_W-1:0]      action,
  output logic [arpc_pkg::MAC_W-1:0]         frame_dst_mac,
  output logic [arpc_pkg::AOP_W-1:0]         arp_opcode,
  output logic [arpc_pkg::IP_W-1:0]          arp_sender_ip,
  output logic [arpc_pkg::MAC_W-1:0]         arp_target_mac,
  output logic [arpc_pkg::IP_W-1:0]          arp_target_ip,
  output logic [arpc_pkg::MAC_W-1:0]         resolved_mac,
  output logic                               learned,
  output logic                               table_full,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [3:0]                    paddr,
  input  wire logic [63:0]                   pwdata,
  output logic [63:0]                        prdata,
  output logic                               pready
);
  import arpc_pkg::*;

  localparam logic REG_OWN_IP  = 1'b0;
  localparam logic REG_OWN_MAC = 1'b1;

  logic [IP_W-1:0]  own_ip;
  logic [MAC_W-1:0] own_mac;
  logic             cfg_wr;
  cmd_t             cmd;
  stat_t            stat;
  res_t             res;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= '0;
      own_mac <= '0;
    end else if (cfg_wr) begin
      case (paddr[3])
        REG_OWN_IP:  own_ip  <= pwdata[IP_W-1:0];
        REG_OWN_MAC: own_mac <= pwdata[MAC_W-1:0];
        default:     own_ip  <= own_ip;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_OWN_IP:  prdata = {{(64-IP_W){1'b0}}, own_ip};
      REG_OWN_MAC: prdata = {{(64-MAC_W){1'b0}}, own_mac};
      default:     prdata = '0;
    endcase
  end

  // Controller
  arpc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath
  arpc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .own_ip     (own_ip),
    .mode       (mode),
    .opcode     (opcode),
    .sender_mac (sender_mac),
    .sender_ip  (sender_ip),
    .target_ip  (target_ip),
    .res        (res)
  );

  // Result ports
  assign action         = res.action;
  assign frame_dst_mac  = res.frame_dst_mac;
  assign arp_opcode     = res.arp_opcode;
  assign arp_sender_ip  = res.arp_sender_ip;
  assign arp_target_mac = res.arp_target_mac;
  assign arp_target_ip  = res.arp_target_ip;
  assign resolved_mac   = res.resolved_mac;
  assign learned        = res.learned;
  assign table_full     = res.table_full;

  // Assertions
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_learn_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(learned && table_full))
    else $error("learned and table_full both set");

  a_action_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (action <= ACT_BCAST))
    else $error("action code out of range");

endmodule

`default_nettype wire

@@ bench/arp_cache_responder_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ARP cache responder testbench
// Drives received ARP packets and resolve transactions through the command
// port, programs own_ip/own_mac over APB between phases, and checks every
// result against an in-bench model of the cache, responder and resolver,
// or against the expected result given in a row of the directed table.

module arp_cache_responder_tb;
  import arpc_pkg::*;

  localparam int          CACHE_DEPTH  = 16;
  localparam int          REG_OWN_IP   = 0;
  localparam int          REG_OWN_MAC  = 1;
  localparam int          REG_STRIDE   = 8;   // own_mac is wider than 32 bits
  localparam int          NUM_PHASES   = 6;
  localparam int          PHASE_ITEMS  = 292;
  localparam int          TAIL_CYCLES  = 25;  // longer than the longest scan
  localparam int          LIMIT_CYCLES = 1000000;
  localparam bit [31:0]   DIR_IP       = 32'h0A00_0001;
  localparam bit [47:0]   DIR_MAC      = 48'h0200_0000_0001;

  // One command transaction
  typedef struct packed {
    bit        mode;
    bit [15:0] opcode;
    bit [47:0] smac;
    bit [31:0] sip;
    bit [31:0] tip;
  } arp_item_t;

  // One row of the directed table
  typedef struct {
    arp_item_t item;
    bit        typed;
    res_t      res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  wire  mode;
  wire  [OPCODE_W-1:0] opcode;
  wire  [MAC_W-1:0]    sender_mac;
  wire  [IP_W-1:0]     sender_ip;
  wire  [IP_W-1:0]     target_ip;
  logic done;
  logic [ACTION_W-1:0] action;
  logic [MAC_W-1:0]    frame_dst_mac;
  logic [AOP_W-1:0]    arp_opcode;
  logic [IP_W-1:0]     arp_sender_ip;
  logic [MAC_W-1:0]    arp_target_mac;
  logic [IP_W-1:0]     arp_target_ip;
  logic [MAC_W-1:0]    resolved_mac;
  logic learned;
  logic table_full;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  arp_item_t  drv_item;
  bit         typed_valid;
  res_t       typed_res;
  res_t       pending_results[$];
  dir_row_t   dir_rows[$];
  bit [31:0]  ip_history[$];
  int         mismatch_count = 0;
  int         result_count = 0;
  int         cycle_count = 0;

  // Shadow of the block's registers and cache contents
  bit [31:0]  cfg_own_ip;
  bit [47:0]  cfg_own_mac;
  bit [31:0]  cache_ip[CACHE_DEPTH];
  bit [47:0]  cache_mac[CACHE_DEPTH];
  int         cache_count;

  assign mode       = drv_item.mode;
  assign opcode     = drv_item.opcode;
  assign sender_mac = drv_item.smac;
  assign sender_ip  = drv_item.sip;
  assign target_ip  = drv_item.tip;

  arp_cache_responder #(.TABLE_ENTRIES(CACHE_DEPTH)) u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Cache model
  // ------------------------------------------------------------------
  function automatic int cache_find(bit [31:0] ip);
    for (int i = 0; i < cache_count; i++)
      if (cache_ip[i] == ip) return i;
    return -1;
  endfunction

  // Returns {dropped, inserted}; a known IP keeps its first MAC
  function automatic bit [1:0] cache_learn(bit [31:0] ip, bit [47:0] mac);
    if (cache_find(ip) >= 0) return 2'b00;
    if (cache_count >= CACHE_DEPTH) return 2'b10;
    cache_ip[cache_count]  = ip;
    cache_mac[cache_count] = mac;
    cache_count++;
    return 2'b01;
  endfunction

  function automatic res_t arp_cache_predict(arp_item_t it);
    res_t r;
    int   idx;
    r = '0;
    if (it.mode == 1'b0) begin
      if (it.opcode == OP_REQUEST) begin
        r.action = ACT_HANDLED;
        // only a request for our own address is answered and learned
        if (it.tip == cfg_own_ip) begin
          {r.table_full, r.learned} = cache_learn(it.sip, it.smac);
          r.action         = ACT_REPLY;
          r.frame_dst_mac  = it.smac;
          r.arp_opcode     = AOP_REPLY;
          r.arp_sender_ip  = it.tip;
          r.arp_target_mac = it.smac;
          r.arp_target_ip  = it.sip;
        end
      end else if (it.opcode == OP_REPLY) begin
        {r.table_full, r.learned} = cache_learn(it.sip, it.smac);
        r.action = ACT_HANDLED;
      end
    end else if (it.tip == BCAST_IP) begin
      r.action       = ACT_BCAST;
      r.resolved_mac = BCAST_MAC;
    end else begin
      idx = cache_find(it.tip);
      if (idx >= 0) begin
        r.action       = ACT_HIT;
        r.resolved_mac = cache_mac[idx];
      end else begin
        r.action        = ACT_MISS;
        r.frame_dst_mac = BCAST_MAC;
        r.arp_opcode    = AOP_REQUEST;
        r.arp_sender_ip = cfg_own_ip;
        r.arp_target_ip = it.tip;
      end
    end
    return r;
  endfunction

  function automatic string res_text(res_t r);
    return $sformatf("act=%0d dst=%h op=%0d sip=%h tmac=%h tip=%h rmac=%h lrn=%b full=%b",
                     r.action, r.frame_dst_mac, r.arp_opcode, r.arp_sender_ip,
                     r.arp_target_mac, r.arp_target_ip, r.resolved_mac, r.learned,
                     r.table_full);
  endfunction

  // ------------------------------------------------------------------
  // Monitor: check results first, then predict the accepted transaction
  // ------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    res_t  got;
    res_t  want;
    string diff;
    if (!rst) begin
      if (done) begin
        got = res_t'{action, frame_dst_mac, arp_opcode, arp_sender_ip, arp_target_mac,
                     arp_target_ip, resolved_mac, learned, table_full};
        result_count++;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result %0d with no transaction pending: %s",
                     result_count, res_text(got));
        end else begin
          want = pending_results.pop_front();
          diff = "";
          if (got.action         !== want.action)         diff = {diff, " action"};
          if (got.frame_dst_mac  !== want.frame_dst_mac)  diff = {diff, " frame_dst_mac"};
          if (got.arp_opcode     !== want.arp_opcode)     diff = {diff, " arp_opcode"};
          if (got.arp_sender_ip  !== want.arp_sender_ip)  diff = {diff, " arp_sender_ip"};
          if (got.arp_target_mac !== want.arp_target_mac) diff = {diff, " arp_target_mac"};
          if (got.arp_target_ip  !== want.arp_target_ip)  diff = {diff, " arp_target_ip"};
          if (got.resolved_mac   !== want.resolved_mac)   diff = {diff, " resolved_mac"};
          if (got.learned        !== want.learned)        diff = {diff, " learned"};
          if (got.table_full     !== want.table_full)     diff = {diff, " table_full"};
          if (diff != "") begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("ERROR: result %0d differs in%s", result_count, diff);
              $display("  expected %s", res_text(want));
              $display("  actual   %s", res_text(got));
            end
          end
        end
      end
      if (start && !busy) begin
        want = arp_cache_predict(drv_item);
        pending_results.push_back(typed_valid ? typed_res : want);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("arp_cache_responder_tb: done, errors");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Driver helpers (called at the falling edge)
  // ------------------------------------------------------------------
  task automatic issue(arp_item_t it, bit typed, res_t res, int unsigned gap);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    drv_item    = it;
    typed_valid = typed;
    typed_res   = res;
    start       = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain_all();
    start = 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic apb_write(int idx, bit [63:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 4'(idx * REG_STRIDE);
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_OWN_IP:  cfg_own_ip  = val[31:0];
      REG_OWN_MAC: cfg_own_mac = val[47:0];
      default: ;
    endcase
  endtask

  task automatic set_identity(bit [31:0] ip, bit [47:0] mac);
    drain_all();
    apb_write(REG_OWN_IP, {32'h0, ip});
    apb_write(REG_OWN_MAC, {16'h0, mac});
  endtask

  function automatic void add_row(bit m, bit [15:0] op, bit [47:0] smac, bit [31:0] sip,
                                  bit [31:0] tip, bit typed, res_t res);
    dir_row_t row;
    row.item  = '{m, op, smac, sip, tip};
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endfunction

  // ------------------------------------------------------------------
  // Random content
  // ------------------------------------------------------------------
  function automatic bit [47:0] rand_mac();
    bit [63:0] w;
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return BCAST_MAC;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  // Mostly addresses seen before so the cache fills slowly and hits are common
  function automatic bit [31:0] pick_ip();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return '0;
    if (r < 4) return BCAST_IP;
    if (r < 10 || ip_history.size() == 0) return $urandom;
    return ip_history[$urandom_range(0, ip_history.size() - 1)];
  endfunction

  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic arp_item_t rand_item();
    arp_item_t   it;
    int unsigned k;
    it.mode   = 1'b0;
    it.opcode = 16'($urandom);
    it.smac   = rand_mac();
    it.sip    = pick_ip();
    it.tip    = $urandom;
    k = $urandom_range(0, 99);
    if (k < 35) begin
      // request, usually for our own address
      it.opcode = OP_REQUEST;
      it.tip    = ($urandom_range(0, 3) != 0) ? cfg_own_ip : pick_ip();
      ip_history.push_back(it.sip);
    end else if (k < 55) begin
      it.opcode = OP_REPLY;
      ip_history.push_back(it.sip);
    end else if (k < 85) begin
      it.mode = 1'b1;
      if ($urandom_range(0, 9) == 0)      it.tip = BCAST_IP;
      else if ($urandom_range(0, 2) != 0) it.tip = pick_ip();
    end else if (k < 92) begin
      it.opcode = 16'($urandom_range(0, 7));
    end
    return it;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  initial begin : stimulus
    arp_item_t it;
    int        counted;
    bit        steady;
    drv_item    = '0;
    typed_valid = 1'b0;
    typed_res   = '0;
    start       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cfg_own_ip  = '0;
    cfg_own_mac = '0;
    cache_count = 0;
    rst         = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_identity(DIR_IP, DIR_MAC);

    // Directed table: empty cache first, then learning and lookups
    add_row(1'b1, 16'h0, 48'h0, 32'h0, BCAST_IP, 1'b1,
            res_t'{ACT_BCAST, 48'h0, AOP_NONE, 32'h0, 48'h0, 32'h0, BCAST_MAC, 1'b0, 1'b0});
    add_row(1'b1, 16'h0, 48'h0, 32'h0, 32'h0, 1'b1,
            res_t'{ACT_MISS, BCAST_MAC, AOP_REQUEST, DIR_IP, 48'h0, 32'h0, 48'h0, 1'b0, 1'b0});
    add_row(1'b1, 16'hFFFF, BCAST_MAC, BCAST_IP, 32'hFFFF_FFFE, 1'b0, '0);
    add_row(1'b0, 16'h0000, 48'h0, 32'h0, DIR_IP, 1'b1, '0);
    add_row(1'b0, 16'hFFFF, BCAST_MAC, BCAST_IP, DIR_IP, 1'b1, '0);
    add_row(1'b0, 16'h0003, 48'h0, 32'h0, DIR_IP, 1'b1, '0);
    add_row(1'b0, 16'h8001, 48'h0, 32'h0, DIR_IP, 1'b1, '0);
    // request for somebody else: acknowledged only
    add_row(1'b0, OP_REQUEST, 48'hAAAA_BBBB_CCCC, 32'hC0A8_0101, 32'h0A00_0002, 1'b1,
            res_t'{ACT_HANDLED, 48'h0, AOP_NONE, 32'h0, 48'h0, 32'h0, 48'h0, 1'b0, 1'b0});
    add_row(1'b0, OP_REQUEST, 48'hAAAA_BBBB_CCCC, 32'hC0A8_0101, DIR_IP, 1'b0, '0);
    // same sender again with a new MAC: first MAC stays
    add_row(1'b0, OP_REQUEST, 48'h1111_2222_3333, 32'hC0A8_0101, DIR_IP, 1'b0, '0);
    add_row(1'b1, 16'h0, 48'h0, 32'h0, 32'hC0A8_0101, 1'b0, '0);
    add_row(1'b0, OP_REPLY, 48'h0, 32'h0, 32'h0, 1'b0, '0);
    add_row(1'b0, OP_REPLY, BCAST_MAC, BCAST_IP, BCAST_IP, 1'b0, '0);
    // all-ones resolves to broadcast even when cached
    add_row(1'b1, 16'h0, 48'h0, 32'h0, BCAST_IP, 1'b1,
            res_t'{ACT_BCAST, 48'h0, AOP_NONE, 32'h0, 48'h0, 32'h0, BCAST_MAC, 1'b0, 1'b0});
    add_row(1'b1, 16'h0, 48'h0, 32'h0, 32'h0, 1'b0, '0);
    add_row(1'b0, OP_REPLY, 48'h0000_0000_0123, BCAST_IP, 32'h0, 1'b0, '0);

    foreach (dir_rows[i])
      issue(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res, pick_gap(1'b0));

    // Random phases, each with its own identity; one phase runs back to back
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       set_identity(BCAST_IP, BCAST_MAC);
        1:       set_identity('0, '0);
        2:       set_identity(DIR_IP, DIR_MAC);
        default: set_identity($urandom, rand_mac());
      endcase
      steady  = (ph == 2);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        it = rand_item();
        counted++;
        issue(it, 1'b0, '0, pick_gap(steady));
      end
    end

    drain_all();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("arp_cache_responder_tb: done, clean");
    end else begin
      $display("arp_cache_responder_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/arpc_pkg.sv
rtl/arpc_ctrl.sv
rtl/arpc_dp.sv
rtl/arp_cache_responder.sv
bench/arp_cache_responder_tb.sv
